// ----- hdl/lcdnw_pkg.sv -----
// Shared types, request codes and the power-up command table for the
// LCD nibble write sequencer. No dependencies.

package lcdnw_pkg;

    // Request codes on the op field
    localparam logic [2:0] OP_DATA   = 3'd0;
    localparam logic [2:0] OP_CMD    = 3'd1;
    localparam logic [2:0] OP_CURSOR = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_INIT   = 3'd4;

    // HD44780 command bytes and timing
    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [7:0] CMD_DDRAM       = 8'h80;
    localparam logic [6:0] ROW1_OFFSET     = 7'h40;
    localparam logic [7:0] POWERUP_TICKS   = 8'd150;
    localparam logic [7:0] STROBE_TICKS    = 8'd1;
    localparam logic [7:0] SETTLE_TICKS    = 8'd2;
    localparam logic [5:0] CURSOR_EXTRA    = 6'd1;
    localparam logic [5:0] CLEAR_EXTRA     = 6'd20;

    // Power-up command list: seven bytes after the leading wait
    localparam int unsigned INIT_BYTES = 7;
    localparam int unsigned BIDX_W     = $clog2(INIT_BYTES);
    localparam logic [BIDX_W-1:0] INIT_LAST_IDX = BIDX_W'(INIT_BYTES - 1);

    // Decoupling queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    // One classified request as the back end sees it
    typedef struct packed {
        logic       is_init;
        logic [7:0] cmd_byte;
        logic       rs;
        logic [5:0] extra;
    } lcdnw_desc_t;

    // Queue status toward the front end and the top level
    typedef struct packed {
        logic                full;
        logic                empty;
        logic [QCOUNT_W-1:0] count;
    } lcdnw_qstat_t;

    // Byte of the power-up list at a given position
    function automatic logic [7:0] init_byte(input logic [BIDX_W-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h0C;
            3'd4:    b = CMD_CLEAR;
            3'd5:    b = 8'h06;
            3'd6:    b = CMD_DDRAM;
            default: b = CMD_DDRAM;
        endcase
        return b;
    endfunction

    // Wait merged into the last hold of that byte
    function automatic logic [5:0] init_extra(input logic [BIDX_W-1:0] idx);
        logic [5:0] e;
        unique case (idx)
            3'd0:    e = 6'd50;
            3'd4:    e = CLEAR_EXTRA;
            default: e = CURSOR_EXTRA;
        endcase
        return e;
    endfunction

endpackage

// ----- hdl/lcdnw_front.sv -----
// Front end: takes requests, classifies them and pushes a descriptor.
// Depends on lcdnw_pkg.

module lcdnw_front (
    input  logic                  in_valid,
    input  logic [2:0]            op,
    input  logic [7:0]            data_byte,
    input  logic                  row,
    input  logic [5:0]            column,
    input  logic                  q_full,
    output logic                  in_stall,
    output logic                  push,
    output lcdnw_pkg::lcdnw_desc_t push_data
);

    logic       known_op;
    logic [6:0] addr_sum;

    // Stall only while the queue has no room
    assign in_stall = q_full;

    // Build the cursor address command
    assign addr_sum = {1'b0, column} + (row ? lcdnw_pkg::ROW1_OFFSET : 7'h00);

    // Classify the request
    always_comb
    begin
        known_op           = 1'b1;
        push_data.is_init  = 1'b0;
        push_data.cmd_byte = data_byte;
        push_data.rs       = 1'b0;
        push_data.extra    = 6'd0;
        unique case (op)
            lcdnw_pkg::OP_DATA:
            begin
                push_data.rs = 1'b1;
            end
            lcdnw_pkg::OP_CMD:
            begin
                push_data.rs = 1'b0;
            end
            lcdnw_pkg::OP_CURSOR:
            begin
                push_data.cmd_byte = lcdnw_pkg::CMD_DDRAM | {1'b0, addr_sum};
                push_data.extra    = lcdnw_pkg::CURSOR_EXTRA;
            end
            lcdnw_pkg::OP_CLEAR:
            begin
                push_data.cmd_byte = lcdnw_pkg::CMD_CLEAR;
                push_data.extra    = lcdnw_pkg::CLEAR_EXTRA;
            end
            lcdnw_pkg::OP_INIT:
            begin
                push_data.is_init  = 1'b1;
                push_data.cmd_byte = 8'h00;
            end
            default:
            begin
                known_op = 1'b0;
            end
        endcase
    end

    // Drop unknown requests, push the rest
    assign push = in_valid && !q_full && known_op;

endmodule

// ----- hdl/lcdnw_queue.sv -----
// Short descriptor queue between the front and back ends.
// Depends on lcdnw_pkg.

module lcdnw_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lcdnw_pkg::lcdnw_desc_t push_data,
    input  logic                   pop,
    output lcdnw_pkg::lcdnw_desc_t pop_data,
    output lcdnw_pkg::lcdnw_qstat_t stat
);

    lcdnw_pkg::lcdnw_desc_t                 mem [lcdnw_pkg::QUEUE_DEPTH];
    logic [lcdnw_pkg::QUEUE_AW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [lcdnw_pkg::QUEUE_AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [lcdnw_pkg::QCOUNT_W-1:0]         count_reg, count_next;
    logic                                   do_push, do_pop;

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == lcdnw_pkg::QCOUNT_W'(lcdnw_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data   = mem[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/lcdnw_back.sv -----
// Back end: expands one descriptor into nibble pin states, one per cycle while
// out_stall is low, through an output register. Depends on lcdnw_pkg.

module lcdnw_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  lcdnw_pkg::lcdnw_desc_t pop_data,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [3:0]             data_nibble,
    output logic                   reg_select,
    output logic                   enable,
    output logic [7:0]             hold_ticks,
    output logic                   last
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WAIT = 3'b010,
        ST_SEND = 3'b100
    } back_state_t;

    back_state_t                       state_reg, state_next;
    lcdnw_pkg::lcdnw_desc_t            desc_reg, desc_next;
    logic [lcdnw_pkg::BIDX_W-1:0]      bidx_reg, bidx_next;
    logic [1:0]                        step_reg, step_next;
    logic                              out_valid_reg, out_valid_next;
    logic [3:0]                        nib_reg, nib_next;
    logic                              rs_reg, rs_next;
    logic                              en_reg, en_next;
    logic [7:0]                        hold_reg, hold_next;
    logic                              last_reg, last_next;
    logic                              load;
    logic                              emit;
    logic [7:0]                        cur_byte;
    logic [5:0]                        cur_extra;
    logic                              final_byte;

    // Output register frees up when empty or taken
    assign load = !out_valid_reg || !out_stall;

    assign cur_byte   = desc_reg.is_init ? lcdnw_pkg::init_byte(bidx_reg) : desc_reg.cmd_byte;
    assign cur_extra  = desc_reg.is_init ? lcdnw_pkg::init_extra(bidx_reg) : desc_reg.extra;
    assign final_byte = !desc_reg.is_init || (bidx_reg == lcdnw_pkg::INIT_LAST_IDX);

    // Sequence the pin states
    always_comb
    begin
        state_next = state_reg;
        desc_next  = desc_reg;
        bidx_next  = bidx_reg;
        step_next  = step_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        nib_next   = nib_reg;
        rs_next    = rs_reg;
        en_next    = en_reg;
        hold_next  = hold_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    desc_next  = pop_data;
                    bidx_next  = '0;
                    step_next  = 2'd0;
                    state_next = pop_data.is_init ? ST_WAIT : ST_SEND;
                end
            end
            ST_WAIT:
            begin
                if (load)
                begin
                    emit       = 1'b1;
                    nib_next   = 4'h0;
                    rs_next    = 1'b0;
                    en_next    = 1'b0;
                    hold_next  = lcdnw_pkg::POWERUP_TICKS;
                    last_next  = 1'b0;
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (load)
                begin
                    emit      = 1'b1;
                    nib_next  = step_reg[1] ? cur_byte[3:0] : cur_byte[7:4];
                    rs_next   = desc_reg.rs;
                    en_next   = !step_reg[0];
                    last_next = (step_reg == 2'd3) && final_byte;
                    if (!step_reg[0])
                    begin
                        hold_next = lcdnw_pkg::STROBE_TICKS;
                    end
                    else if (step_reg[1])
                    begin
                        hold_next = lcdnw_pkg::SETTLE_TICKS + {2'b00, cur_extra};
                    end
                    else
                    begin
                        hold_next = lcdnw_pkg::SETTLE_TICKS;
                    end
                    step_next = step_reg + 1'b1;
                    if (step_reg == 2'd3)
                    begin
                        if (final_byte)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            bidx_next = bidx_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = load ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bidx_reg      <= '0;
            step_reg      <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bidx_reg      <= bidx_next;
            step_reg      <= step_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        nib_reg  <= nib_next;
        rs_reg   <= rs_next;
        en_reg   <= en_next;
        hold_reg <= hold_next;
        last_reg <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign data_nibble = nib_reg;
    assign reg_select  = rs_reg;
    assign enable      = en_reg;
    assign hold_ticks  = hold_reg;
    assign last        = last_reg;

endmodule

// ----- hdl/lcd_nibble_write_sequencer_unit.sv -----
// Top level of the LCD nibble write sequencer: front end, descriptor queue,
// back end. Depends on lcdnw_pkg, lcdnw_front, lcdnw_queue, lcdnw_back.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   in      | in_valid, in_stall  | op, data_byte, row, column
//   out     | out_valid, out_stall| data_nibble, reg_select, enable,
//           |                     | hold_ticks, last
//
// A byte request gives 4 pin states and init gives 29; the back end pops the queue
// in its idle state, then gives one state per cycle while out_stall is low. The back
// end sequencer and its single output register set that pace.
// The front end takes requests while the 4-entry queue has room, so it runs
// ahead of a stalled output. Unknown op codes are taken and dropped.
// Reset is asynchronous, active low, and empties the queue and the output.

module lcd_nibble_write_sequencer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] op,
    input  logic [7:0] data_byte,
    input  logic       row,
    input  logic [5:0] column,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] data_nibble,
    output logic       reg_select,
    output logic       enable,
    output logic [7:0] hold_ticks,
    output logic       last
);

    logic                     push;
    logic                     pop;
    lcdnw_pkg::lcdnw_desc_t   push_data;
    lcdnw_pkg::lcdnw_desc_t   pop_data;
    lcdnw_pkg::lcdnw_qstat_t  q_stat;

    // Classify requests
    lcdnw_front u_front (
        .in_valid  (in_valid),
        .op        (op),
        .data_byte (data_byte),
        .row       (row),
        .column    (column),
        .q_full    (q_stat.full),
        .in_stall  (in_stall),
        .push      (push),
        .push_data (push_data)
    );

    // Hold pending requests
    lcdnw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    // Expand into pin states
    lcdnw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_stat.empty),
        .pop_data    (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_nibble (data_nibble),
        .reg_select  (reg_select),
        .enable      (enable),
        .hold_ticks  (hold_ticks),
        .last        (last)
    );

    // Strobe states are one tick long
    a_strobe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && enable |-> hold_ticks == lcdnw_pkg::STROBE_TICKS)
        else $error("strobe state with wrong hold");

    // The closing state of a request has EN low
    a_last_en_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> !enable)
        else $error("last state with EN high");

    // Queue count stays within depth
    a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= lcdnw_pkg::QCOUNT_W'(lcdnw_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");

    // A taken strobe is followed by its EN-low state on the same nibble
    a_strobe_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && enable |=>
            out_valid && !enable && data_nibble == $past(data_nibble))
        else $error("strobe not followed by settle state");

endmodule
